[src/pts_pkg.sv]
// Shared types and constants for the PWM timing set-up engine.
// Used by pts_mul, pts_div and pwm_timing_setup_top; depends on nothing.
`timescale 1ns / 1ps
package pts_pkg;

  // Default channel count.
  localparam int NUM_CHANNELS_DEF = 4;

  // Arithmetic constants.
  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [63:0] PSC_LIMIT  = 64'h0000_0000_0000_FFFF;

  // Serial unit step counts.
  localparam int MUL_B_W   = 33;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int DIV_W     = 64;
  localparam int DIV_STEPS = DIV_W;

  // Stream payload widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 96;

  // Request kinds.
  localparam logic [1:0] REQ_APPLY   = 2'd0;
  localparam logic [1:0] REQ_ENABLE  = 2'd1;
  localparam logic [1:0] REQ_DISABLE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_HZ   = 2'd0;
  localparam logic [1:0] CFG_MAX_RELOAD = 2'd1;
  localparam logic [1:0] CFG_COMP_OUT   = 2'd2;

  // Reset values.
  localparam logic [31:0] CLOCK_HZ_RST   = 32'd90000000;
  localparam logic [31:0] MAX_RELOAD_RST = 32'd65535;
  localparam logic [15:0] PRESCALER_RST  = 16'd1;
  localparam logic [31:0] RELOAD_RST     = 32'd10000;

  // Handshake between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[src/pts_mul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on pts_pkg for the handshake structs and the step count.
`timescale 1ns / 1ps
module pts_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pts_pkg::unit_ctl_t           ctl,
  input  logic [63:0]                  a,
  input  logic [pts_pkg::MUL_B_W-1:0]  b,
  output pts_pkg::unit_sts_t           sts,
  output logic [63:0]                  prod
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [63:0]      acc_r;
  logic [63:0]      a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [63:0]      acc_nxt;

  // Add the shifted multiplicand when the current multiplier bit is set.
  assign acc_nxt = b_r[0] ? acc_r + a_r : acc_r;

  // Load on start, then step once per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      acc_r  <= '0;
      a_r    <= '0;
      b_r    <= '0;
    end else begin
      // Done is a one-cycle pulse.
      if (done_r) begin
        done_r <= 1'b0;
      end
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MUL_STEPS);
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[62:0], 1'b0};
        b_r   <= {1'b0, b_r[MUL_B_W-1:1]};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

[src/pts_div.sv]
// Restoring divider: one quotient bit per cycle, 64-bit operands.
// Depends on pts_pkg; the divisor must be nonzero and below 2**63.
`timescale 1ns / 1ps
module pts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pts_pkg::unit_ctl_t          ctl,
  input  logic [pts_pkg::DIV_W-1:0]   num,
  input  logic [pts_pkg::DIV_W-1:0]   den,
  output pts_pkg::unit_sts_t          sts,
  output logic [pts_pkg::DIV_W-1:0]   quo
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] q_r;
  logic [DIV_W-1:0] d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W-1:0] trial;
  logic             fits;

  // Bring down the next dividend bit and try the subtract.
  assign trial = {rem_r[DIV_W-2:0], q_r[DIV_W-1]};
  assign fits  = trial >= d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      q_r    <= '0;
      d_r    <= '0;
    end else begin
      // Done is a one-cycle pulse.
      if (done_r) begin
        done_r <= 1'b0;
      end
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS);
        rem_r  <= '0;
        q_r    <= num;
        d_r    <= den;
      end else if (busy_r) begin
        rem_r <= fits ? trial - d_r : trial;
        q_r   <= {q_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

[src/pwm_timing_setup_top.sv]
// PWM timing set-up engine: sequencer, timer state and stream ports.
// Depends on pts_pkg, pts_mul and pts_div.
//
// Input stream in_*: one request per item (apply, enable or disable a
// channel). Result stream out_*: exactly one item per request, showing the
// status and the timer state after the request.
// Configuration channel cfg_*: index 0 clock_hz, 1 max_reload,
// 2 complementary_output; always ready; the user must write it only while
// idle, which the block itself does not enforce. Enable, disable and
// rejected channel or kind requests go from idle to the finishing step,
// which presents the result once the output register is free; the input
// takes the next item only back in idle. An apply request runs four
// products through the serial multiplier (each a start, a load and 33
// steps) and three quotients through the restoring divider (each a start,
// a load and 64 steps); it ends early after two products and one quotient
// when the prescaler is out of range, and after three products and two
// quotients when the count is zero or the shared timebase is busy. One
// request is worked on at a time; in_tready is high only between requests.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; if the receiver stalls, the finished
// request holds in its last step until the register frees.
// Reset (rst_n low, synchronous) restores the configuration and timer
// registers to their defaults and drops any request in flight.
`timescale 1ns / 1ps
module pwm_timing_setup_top #(
  parameter int NUM_CHANNELS = pts_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: channel[2:0], period[34:3], duty_ns[66:35], polarity[67]
  input  logic [pts_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: prescaler_out[15:0], reload_out[47:16], compare_out[79:48],
  // enable_mask[83:80], pol_bits[87:84], comp_pol_bits[91:88]
  output logic [pts_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [31:0]                     cfg_data
);
  import pts_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_T,
    S_MUL_D1,
    S_DIV_P,
    S_MUL_D2,
    S_DIV_CNT,
    S_MUL_C,
    S_DIV_CMP,
    S_FINISH
  } state_t;

  state_t            state_r;

  // Configuration.
  logic [31:0]       clock_hz_r;
  logic [31:0]       max_reload_r;
  logic              comp_out_r;

  // Timer state.
  logic [15:0]       prescaler_r;
  logic [31:0]       reload_r;
  logic [31:0]       cmp_r [NUM_CHANNELS];
  logic [3:0]        enable_r;
  logic [3:0]        pol_mask_r;
  logic [3:0]        comp_mask_r;

  // Request in flight.
  logic              ch_ok_r;
  logic [IDX_W-1:0]  idx_r;
  logic [3:0]        bit_r;
  logic [31:0]       duty_r;
  logic [1:0]        status_r;
  logic [63:0]       t_r;
  logic [63:0]       d2_r;
  logic [15:0]       psc_new_r;

  // Serial unit operands.
  logic              mul_start_r;
  logic [63:0]       mul_a_r;
  logic [MUL_B_W-1:0] mul_b_r;
  logic              div_start_r;
  logic [63:0]       div_n_r;
  logic [63:0]       div_d_r;

  // Output register.
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  unit_ctl_t         mul_ctl;
  unit_ctl_t         div_ctl;
  unit_sts_t         mul_sts;
  unit_sts_t         div_sts;
  logic [63:0]       mul_prod;
  logic [63:0]       div_q;

  // Input field decode.
  logic [1:0]        in_req;
  logic [2:0]        in_ch;
  logic [31:0]       in_period;
  logic [31:0]       in_duty;
  logic              in_pol;
  logic [2:0]        in_ch_m1;
  logic              in_ch_ok;
  logic [3:0]        in_bit;

  assign in_req    = in_tuser;
  assign in_ch     = in_tdata[2:0];
  assign in_period = in_tdata[34:3];
  assign in_duty   = in_tdata[66:35];
  assign in_pol    = in_tdata[67];
  assign in_ch_m1  = in_ch - 3'd1;
  assign in_ch_ok  = (in_ch != 3'd0) && (32'(in_ch) <= 32'(NUM_CHANNELS));
  assign in_bit    = 4'b0001 << in_ch_m1;

  // Step checks on the divider result, plus the output-free test and the compare select.
  logic [63:0]       cnt_m1;
  logic              others_on;
  logic              base_differs;
  logic [31:0]       cmp_sat;
  logic              out_free;
  logic [31:0]       cmp_sel;

  assign cnt_m1       = div_q - 64'd1;
  assign others_on    = |(enable_r & ~bit_r);
  assign base_differs = (psc_new_r != prescaler_r) || (cnt_m1 != {32'd0, reload_r});
  assign cmp_sat      = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
  assign out_free     = !out_valid_r || out_tready;
  assign cmp_sel      = ch_ok_r ? cmp_r[idx_r] : 32'd0;

  assign mul_ctl.start = mul_start_r;
  assign div_ctl.start = div_start_r;

  pts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  pts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_n_r),
    .den   (div_d_r),
    .sts   (div_sts),
    .quo   (div_q)
  );

  // Sequencer, timer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clock_hz_r   <= CLOCK_HZ_RST;
      max_reload_r <= MAX_RELOAD_RST;
      comp_out_r   <= 1'b0;
      prescaler_r  <= PRESCALER_RST;
      reload_r     <= RELOAD_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmp_r[i] <= '0;
      end
      enable_r     <= '0;
      pol_mask_r   <= '0;
      comp_mask_r  <= '0;
      ch_ok_r      <= 1'b0;
      idx_r        <= '0;
      bit_r        <= '0;
      duty_r       <= '0;
      status_r     <= STAT_OK;
      t_r          <= '0;
      d2_r         <= '0;
      psc_new_r    <= '0;
      mul_start_r  <= 1'b0;
      mul_a_r      <= '0;
      mul_b_r      <= '0;
      div_start_r  <= 1'b0;
      div_n_r      <= '0;
      div_d_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STAT_OK;
      out_data_r   <= '0;
    end else begin
      // Clear each start pulse in the cycle after it is raised.
      if (mul_start_r) begin
        mul_start_r <= 1'b0;
      end
      if (div_start_r) begin
        div_start_r <= 1'b0;
      end

      // Take configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CLOCK_HZ:   clock_hz_r   <= cfg_data;
          CFG_MAX_RELOAD: max_reload_r <= cfg_data;
          CFG_COMP_OUT:   comp_out_r   <= cfg_data[0];
          default: ;
        endcase
      end

      // Drop the result once taken; the finishing step refills it instead.
      if (out_valid_r && out_tready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ch_ok_r <= in_ch_ok;
            idx_r   <= in_ch_m1[IDX_W-1:0];
            bit_r   <= in_bit;
            duty_r  <= in_duty;
            state_r <= (in_ch_ok && in_req == REQ_APPLY) ? S_MUL_T : S_FINISH;
            if (!in_ch_ok) begin
              status_r <= STAT_INVALID;
            end else begin
              case (in_req)
                REQ_APPLY: begin
                  pol_mask_r <= in_pol ? (pol_mask_r | in_bit) : (pol_mask_r & ~in_bit);
                  if (comp_out_r) begin
                    comp_mask_r <= in_pol ? (comp_mask_r | in_bit)
                                          : (comp_mask_r & ~in_bit);
                  end
                  mul_a_r     <= {32'd0, in_period};
                  mul_b_r     <= {1'b0, clock_hz_r};
                  mul_start_r <= 1'b1;
                end
                REQ_ENABLE: begin
                  enable_r <= enable_r | in_bit;
                  status_r <= STAT_OK;
                end
                REQ_DISABLE: begin
                  enable_r <= enable_r & ~in_bit;
                  status_r <= STAT_OK;
                end
                default: begin
                  status_r <= STAT_INVALID;
                end
              endcase
            end
          end
        end
        // T = period * clock; then the prescaler divisor.
        S_MUL_T: begin
          if (mul_sts.done) begin
            t_r         <= mul_prod;
            mul_a_r     <= NS_PER_SEC;
            mul_b_r     <= {1'b0, max_reload_r} + MUL_B_W'(1);
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_D1;
          end
        end
        S_MUL_D1: begin
          if (mul_sts.done) begin
            div_n_r     <= t_r;
            div_d_r     <= mul_prod;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_P;
          end
        end
        // Prescaler: reject when out of range.
        S_DIV_P: begin
          if (div_sts.done) begin
            if (div_q > PSC_LIMIT) begin
              status_r <= STAT_INVALID;
              state_r  <= S_FINISH;
            end else begin
              psc_new_r   <= div_q[15:0];
              mul_a_r     <= NS_PER_SEC;
              mul_b_r     <= MUL_B_W'(div_q[15:0]) + MUL_B_W'(1);
              mul_start_r <= 1'b1;
              state_r     <= S_MUL_D2;
            end
          end
        end
        S_MUL_D2: begin
          if (mul_sts.done) begin
            d2_r        <= mul_prod;
            div_n_r     <= t_r;
            div_d_r     <= mul_prod;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_CNT;
          end
        end
        // Count: reject zero, guard the shared timebase, then commit.
        S_DIV_CNT: begin
          if (div_sts.done) begin
            if (div_q == 64'd0) begin
              status_r <= STAT_INVALID;
              state_r  <= S_FINISH;
            end else if (others_on && base_differs) begin
              status_r <= STAT_BUSY;
              state_r  <= S_FINISH;
            end else begin
              prescaler_r <= psc_new_r;
              reload_r    <= cnt_m1[31:0];
              mul_a_r     <= {32'd0, duty_r};
              mul_b_r     <= {1'b0, clock_hz_r};
              mul_start_r <= 1'b1;
              state_r     <= S_MUL_C;
            end
          end
        end
        S_MUL_C: begin
          if (mul_sts.done) begin
            div_n_r     <= mul_prod;
            div_d_r     <= d2_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_CMP;
          end
        end
        // Compare: saturate to 32 bits.
        S_DIV_CMP: begin
          if (div_sts.done) begin
            cmp_r[idx_r] <= cmp_sat;
            status_r     <= STAT_OK;
            state_r      <= S_FINISH;
          end
        end
        // Hand the result to the output register once it is free.
        S_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_data_r   <= {4'd0, comp_mask_r, pol_mask_r, enable_r,
                             cmp_sel, reload_r, prescaler_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  // The two serial units never run at the same time.
  assert property (@(posedge clk) disable iff (!rst_n) !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  // A unit is only started while it is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start_r |-> !mul_sts.busy) and (div_start_r |-> !div_sts.busy))
    else $error("serial unit restarted while busy");

  // After a request is accepted, in_tready is low in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in flight");

  // Results carry only defined status codes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_OK || out_tuser == STAT_INVALID ||
                    out_tuser == STAT_BUSY))
    else $error("undefined status on result");

endmodule

[dv/tb_pwm_timing_setup_top.sv]
// Self-checking testbench for pwm_timing_setup_top: directed table, then random phases.
// Depends on pts_pkg and the RTL under src; holds its own predictor of the timer state.
`timescale 1ns / 1ps
module tb_pwm_timing_setup_top;
  import pts_pkg::*;

  // Request kind that the block must reject
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLDOFF_LEN   = 1500;
  localparam int IDLE_PCT      = 12;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 110;
  localparam int REPORT_LIMIT  = 10;

  // One result item as seen at the output
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] prescaler;
    logic [31:0] reload;
    logic [31:0] compare;
    logic [3:0]  enable_mask;
    logic [3:0]  pol_bits;
    logic [3:0]  comp_pol_bits;
  } timer_view_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  req;
    logic [2:0]  channel;
    logic [31:0] period_req;
    logic [31:0] duty_ns;
    logic        polarity;
    logic        typed;
    timer_view_t view;
    logic [31:0] clock_hz;
    logic [31:0] max_reload;
    logic        comp_out;
  } plan_row_t;

  // Views that can be read straight off the reset state
  localparam timer_view_t RESET_INVALID =
    '{STAT_INVALID, PRESCALER_RST, RELOAD_RST, 32'd0, 4'h0, 4'h0, 4'h0};
  localparam timer_view_t RESET_INVALID_POL1 =
    '{STAT_INVALID, PRESCALER_RST, RELOAD_RST, 32'd0, 4'h0, 4'h1, 4'h0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  // Predictor copy of configuration and timer state
  logic [31:0] pred_clock_hz;
  logic [31:0] pred_max_reload;
  logic        pred_comp_out;
  logic [15:0] pred_prescaler;
  logic [31:0] pred_reload;
  logic [31:0] pred_compare [4];
  logic [3:0]  pred_enable;
  logic [3:0]  pred_polarity;
  logic [3:0]  pred_comp_polarity;

  timer_view_t expected_views [$];
  plan_row_t   plan [$];
  logic [31:0] last_good_period = 32'd1000000;
  int          fail_count = 0;
  int          idle_cycles = 0;
  logic        holdoff_go = 1'b0;
  logic        holdoff_seen = 1'b0;
  logic        quiet = 1'b0;
  int          holdoff_left = 0;

  string field_names [7] = '{"status", "prescaler", "reload", "compare",
                             "enable_mask", "pol_bits", "comp_pol_bits"};

  pwm_timing_setup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Restore the predictor to its reset state
  task automatic reset_prediction();
    pred_clock_hz      = CLOCK_HZ_RST;
    pred_max_reload    = MAX_RELOAD_RST;
    pred_comp_out      = 1'b0;
    pred_prescaler     = PRESCALER_RST;
    pred_reload        = RELOAD_RST;
    for (int i = 0; i < 4; i++) pred_compare[i] = '0;
    pred_enable        = '0;
    pred_polarity      = '0;
    pred_comp_polarity = '0;
  endtask

  // Advance the predicted timer state by one request and return its view
  function automatic timer_view_t predict_request(logic [1:0] req, logic [2:0] channel,
                                                  logic [31:0] period_req,
                                                  logic [31:0] duty_ns, logic polarity);
    timer_view_t v;
    logic        chan_ok;
    logic [3:0]  bit_m;
    logic [63:0] ticks;
    logic [63:0] psc;
    logic [63:0] cnt;
    logic [63:0] cmp;
    logic [1:0]  st;
    chan_ok = (channel >= 3'd1) && (channel <= 3'd4);
    bit_m   = chan_ok ? (4'b0001 << (channel - 3'd1)) : 4'b0000;
    st      = STAT_INVALID;
    if (chan_ok) begin
      case (req)
        REQ_APPLY: begin
          // Polarity is written before any range check
          pred_polarity = polarity ? (pred_polarity | bit_m) : (pred_polarity & ~bit_m);
          if (pred_comp_out) begin
            pred_comp_polarity = polarity ? (pred_comp_polarity | bit_m)
                                          : (pred_comp_polarity & ~bit_m);
          end
          ticks = {32'd0, period_req} * {32'd0, pred_clock_hz};
          psc   = ticks / (NS_PER_SEC * ({32'd0, pred_max_reload} + 64'd1));
          if (psc > PSC_LIMIT) begin
            st = STAT_INVALID;
          end else begin
            cnt = ticks / (NS_PER_SEC * (psc + 64'd1));
            if (cnt == 64'd0) begin
              st = STAT_INVALID;
            end else if ((pred_enable & ~bit_m) != 4'b0000 &&
                         (psc != {48'd0, pred_prescaler} ||
                          cnt - 64'd1 != {32'd0, pred_reload})) begin
              st = STAT_BUSY;
            end else begin
              pred_prescaler = psc[15:0];
              pred_reload    = cnt[31:0] - 32'd1;
              cmp = ({32'd0, duty_ns} * {32'd0, pred_clock_hz}) / (NS_PER_SEC * (psc + 64'd1));
              if (cmp > 64'h0000_0000_FFFF_FFFF) cmp = 64'h0000_0000_FFFF_FFFF;
              pred_compare[channel - 3'd1] = cmp[31:0];
              st = STAT_OK;
            end
          end
        end
        REQ_ENABLE: begin
          pred_enable = pred_enable | bit_m;
          st = STAT_OK;
        end
        REQ_DISABLE: begin
          pred_enable = pred_enable & ~bit_m;
          st = STAT_OK;
        end
        default: st = STAT_INVALID;
      endcase
    end
    v.status        = st;
    v.prescaler     = pred_prescaler;
    v.reload        = pred_reload;
    v.compare       = chan_ok ? pred_compare[channel - 3'd1] : 32'd0;
    v.enable_mask   = pred_enable;
    v.pol_bits      = pred_polarity;
    v.comp_pol_bits = pred_comp_polarity;
    return v;
  endfunction

  function automatic logic [31:0] field_of(timer_view_t v, int k);
    case (k)
      0:       return {30'd0, v.status};
      1:       return {16'd0, v.prescaler};
      2:       return v.reload;
      3:       return v.compare;
      4:       return {28'd0, v.enable_mask};
      5:       return {28'd0, v.pol_bits};
      default: return {28'd0, v.comp_pol_bits};
    endcase
  endfunction

  function automatic plan_row_t item_row(logic [1:0] req, logic [2:0] channel,
                                         logic [31:0] period_req, logic [31:0] duty_ns,
                                         logic polarity);
    plan_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.req        = req;
    r.channel    = channel;
    r.period_req = period_req;
    r.duty_ns    = duty_ns;
    r.polarity   = polarity;
    return r;
  endfunction

  function automatic plan_row_t checked_row(logic [1:0] req, logic [2:0] channel,
                                            logic [31:0] period_req, logic [31:0] duty_ns,
                                            logic polarity, timer_view_t view);
    plan_row_t r;
    r       = item_row(req, channel, period_req, duty_ns, polarity);
    r.typed = 1'b1;
    r.view  = view;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [31:0] clock_hz, logic [31:0] max_reload,
                                        logic comp_out);
    plan_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.clock_hz   = clock_hz;
    r.max_reload = max_reload;
    r.comp_out   = comp_out;
    return r;
  endfunction

  // Offer one request after any random idle gaps, hold it until taken, then queue its expected view
  task automatic send_request(logic [1:0] req, logic [2:0] channel, logic [31:0] period_req,
                              logic [31:0] duty_ns, logic polarity, logic typed,
                              timer_view_t typed_view);
    timer_view_t v;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'd0, polarity, duty_ns, period_req, channel};
    do @(posedge clk); while (!in_tready);
    v = predict_request(req, channel, period_req, duty_ns, polarity);
    if (req == REQ_APPLY && v.status == STAT_OK) last_good_period = period_req;
    expected_views.push_back(typed ? typed_view : v);
  endtask

  // Wait for the block to drain, then write all three registers
  task automatic program_timer(logic [31:0] clock_hz, logic [31:0] max_reload,
                               logic comp_out);
    logic [31:0] values [3];
    logic [1:0]  regs [3];
    in_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    values = '{clock_hz, max_reload, {31'd0, comp_out}};
    regs   = '{CFG_CLOCK_HZ, CFG_MAX_RELOAD, CFG_COMP_OUT};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= values[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_CLOCK_HZ:   pred_clock_hz   = values[i];
        CFG_MAX_RELOAD: pred_max_reload = values[i];
        default:        pred_comp_out   = values[i][0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Draw one random request, mostly well-formed with a reachable timebase
  task automatic random_request();
    logic [1:0]  req;
    logic [2:0]  channel;
    logic [31:0] period_req;
    logic [31:0] duty_ns;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 60)      req = REQ_APPLY;
    else if (pick < 77) req = REQ_ENABLE;
    else if (pick < 94) req = REQ_DISABLE;
    else                req = REQ_UNKNOWN;
    if ($urandom_range(99) < 8) channel = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(7, 5));
    else                        channel = 3'($urandom_range(4, 1));
    pick = $urandom_range(99);
    if (pick < 35)      period_req = last_good_period;
    else if (pick < 80) period_req = $urandom_range(20000000, 100);
    else                period_req = $urandom;
    if ($urandom_range(99) < 70) duty_ns = $urandom_range(period_req, 0);
    else                         duty_ns = $urandom;
    send_request(req, channel, period_req, duty_ns, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  // Compare accepted results with the oldest expectation
  always @(posedge clk) begin
    timer_view_t got;
    timer_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = out_tuser;
      got.prescaler     = out_tdata[15:0];
      got.reload        = out_tdata[47:16];
      got.compare       = out_tdata[79:48];
      got.enable_mask   = out_tdata[83:80];
      got.pol_bits      = out_tdata[87:84];
      got.comp_pol_bits = out_tdata[91:88];
      if (expected_views.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("unexpected result item %h", got);
      end else begin
        want = expected_views.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            for (int k = 0; k < 7; k++) begin
              if (field_of(got, k) != field_of(want, k))
                $display("%s: expected %0h, got %0h", field_names[k],
                         field_of(want, k), field_of(got, k));
            end
          end
        end
      end
    end
  end

  // Drive the receiver: random stalls, a quiet stretch and one long hold-off
  always @(posedge clk) begin
    if (holdoff_go && !holdoff_seen) begin
      holdoff_seen = 1'b1;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pwm_timing_setup_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] clk_pick;
    logic [31:0] reload_pick;
    reset_prediction();

    // Directed table: reset view, errors, extremes, shared timebase, saturation
    plan.push_back(checked_row(REQ_APPLY, 3'd0, 32'd1000, 32'd0, 1'b1, RESET_INVALID));
    plan.push_back(checked_row(REQ_ENABLE, 3'd7, 32'd0, 32'd0, 1'b0, RESET_INVALID));
    plan.push_back(checked_row(REQ_UNKNOWN, 3'd1, 32'd5000, 32'd10, 1'b1, RESET_INVALID));
    plan.push_back(checked_row(REQ_DISABLE, 3'd5, 32'd0, 32'd0, 1'b0, RESET_INVALID));
    plan.push_back(checked_row(REQ_APPLY, 3'd1, 32'd0, 32'd0, 1'b1, RESET_INVALID_POL1));
    plan.push_back(item_row(REQ_APPLY, 3'd1, 32'd1000000, 32'd500000, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(item_row(REQ_ENABLE, 3'd1, 32'd0, 32'd0, 1'b0));
    plan.push_back(item_row(REQ_ENABLE, 3'd2, 32'd0, 32'd0, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd2, 32'd2000000, 32'd1000, 1'b1));
    plan.push_back(item_row(REQ_APPLY, 3'd2, 32'hFFFF_FFFF, 32'd1234, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd3, 32'd1000000, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(item_row(REQ_DISABLE, 3'd1, 32'd0, 32'd0, 1'b0));
    plan.push_back(item_row(REQ_DISABLE, 3'd2, 32'd0, 32'd0, 1'b0));
    plan.push_back(item_row(REQ_DISABLE, 3'd3, 32'd0, 32'd0, 1'b0));
    plan.push_back(cfg_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(item_row(REQ_APPLY, 3'd3, 32'd10, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(item_row(REQ_APPLY, 3'd2, 32'hFFFF_FFFF, 32'd0, 1'b0));
    plan.push_back(cfg_row(32'hFFFF_FFFF, 32'd1, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd1, 32'hFFFF_FFFF, 32'd100, 1'b1));
    plan.push_back(cfg_row(32'd1, 32'd1, 1'b1));
    plan.push_back(item_row(REQ_APPLY, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd4, 32'd1000, 32'd10, 1'b1));
    plan.push_back(cfg_row(32'd0, MAX_RELOAD_RST, 1'b0));
    plan.push_back(item_row(REQ_APPLY, 3'd1, 32'd1000000, 32'd10, 1'b1));
    plan.push_back(item_row(REQ_ENABLE, 3'd3, 32'd0, 32'd0, 1'b0));
    plan.push_back(item_row(REQ_UNKNOWN, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

    // Hold reset, then release at a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        program_timer(plan[i].clock_hz, plan[i].max_reload, plan[i].comp_out);
      else
        send_request(plan[i].req, plan[i].channel, plan[i].period_req, plan[i].duty_ns,
                     plan[i].polarity, plan[i].typed, plan[i].view);
    end

    // Random phases, each under its own timer settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(5))
        0, 1, 2: clk_pick = $urandom_range(200000000, 1000000);
        3:       clk_pick = 32'd1;
        4:       clk_pick = 32'hFFFF_FFFF;
        default: clk_pick = CLOCK_HZ_RST;
      endcase
      case ($urandom_range(4))
        0:       reload_pick = MAX_RELOAD_RST;
        1:       reload_pick = 32'd255;
        2:       reload_pick = 32'd1;
        3:       reload_pick = 32'hFFFF_FFFF;
        default: reload_pick = $urandom_range(100000, 2);
      endcase
      if (p == 0) begin
        clk_pick    = CLOCK_HZ_RST;
        reload_pick = MAX_RELOAD_RST;
      end
      program_timer(clk_pick, reload_pick, 1'($urandom_range(1)));
      quiet      <= (p == 2);
      holdoff_go <= (p >= 4);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    // Drain and settle
    in_tvalid <= 1'b0;
    quiet     <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_views.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("tb_pwm_timing_setup_top: PASS");
    end else begin
      $display("tb_pwm_timing_setup_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/pts_pkg.sv
src/pts_mul.sv
src/pts_div.sv
src/pwm_timing_setup_top.sv
dv/tb_pwm_timing_setup_top.sv
